// ===== rtl/rdel_pkg.sv =====
// shared constants, request codes and controller/datapath link types
// for the eight-lane rans decoder; no dependencies
package rdel_pkg;

	localparam int LANES      = 8;
	localparam int PROB_WIDTH = 12;
	localparam int SYM_W      = 8;
	localparam int STATE_W    = 32;
	localparam int WORD_W     = 16;
	localparam int LANE_W     = 3;
	localparam int REQ_W      = 2;
	localparam int PTR_W      = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int SLOTS      = 1 << PROB_WIDTH;
	localparam int FQ_W       = PROB_WIDTH + 1;
	localparam int CUM_W      = PROB_WIDTH + 1;
	localparam int CUM_MAX    = (2 << PROB_WIDTH) - 1;
	localparam int ENTRY_W    = SYM_W + PROB_WIDTH + FQ_W;
	localparam int PROD_W     = FQ_W + 1 + STATE_W - PROB_WIDTH;
	localparam int RENORM_LOW = 1 << 16;

	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LANE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEC  = 2'd2;

	typedef struct packed {
		logic ld_accept;
		logic lane_accept;
		logic dec_accept;
		logic fill_en;
		logic dec_rd;
		logic dec_mul;
		logic dec_wb;
	} ctrl_t;

	typedef struct packed {
		logic freq_zero;
		logic fill_last;
	} status_t;

endpackage

// ===== rtl/rdel_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module rdel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rdel_ctrl.sv =====
// sequencing state machine: slot fill loop and decode steps
// depends on rdel_pkg
module rdel_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rdel_pkg::REQ_W-1:0] req_type,
	input  rdel_pkg::status_t          status,
	output rdel_pkg::ctrl_t            ctrl,
	output logic                       busy
);
	import rdel_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_DEC_RD,
		ST_DEC_MUL,
		ST_DEC_WB
	} state_t;

	state_t state_q;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		ctrl             = '0;
		ctrl.ld_accept   = accept && (req_type == REQ_LOAD);
		ctrl.lane_accept = accept && (req_type == REQ_LANE);
		ctrl.dec_accept  = accept && (req_type == REQ_DEC);
		ctrl.fill_en     = (state_q == ST_FILL);
		ctrl.dec_rd      = (state_q == ST_DEC_RD);
		ctrl.dec_mul     = (state_q == ST_DEC_MUL);
		ctrl.dec_wb      = (state_q == ST_DEC_WB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (req_type)
							REQ_LOAD: begin
								// zero frequency only bumps the symbol counter
								if (!status.freq_zero) begin
									state_q <= ST_FILL;
								end
							end
							REQ_DEC: state_q <= ST_DEC_RD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FILL: begin
					if (status.fill_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DEC_RD:  state_q <= ST_DEC_MUL;
				ST_DEC_MUL: state_q <= ST_DEC_WB;
				ST_DEC_WB:  state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/rdel_datapath.sv =====
// slot table, cumulative start, lane states and the decode arithmetic
// depends on rdel_pkg and rdel_ram
module rdel_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rdel_pkg::ctrl_t              ctrl,
	output rdel_pkg::status_t            status,
	input  logic [rdel_pkg::FQ_W-1:0]    freq,
	input  logic                         is_first_symbol,
	input  logic [rdel_pkg::LANE_W-1:0]  lane,
	input  logic [rdel_pkg::STATE_W-1:0] init_state,
	input  logic [rdel_pkg::WORD_W-1:0]  refill_word,
	input  logic                         word_valid,
	output logic                         result_strobe,
	output logic [rdel_pkg::SYM_W-1:0]   symbol,
	output logic                         word_consumed,
	output logic                         underflow_error
);
	import rdel_pkg::*;

	logic [CUM_W-1:0]   cum_q;
	logic [SYM_W-1:0]   sym_cnt_q;
	logic [CUM_W-1:0]   fill_base_q;
	logic [FQ_W-1:0]    fill_freq_q;
	logic [SYM_W-1:0]   fill_sym_q;
	logic [FQ_W-1:0]    fill_idx_q;
	logic [STATE_W-1:0] lane_q [LANES];
	logic [PTR_W-1:0]   ptr_q;
	logic [WORD_W-1:0]  word_q;
	logic               word_valid_q;
	logic [STATE_W-1:0] x_s1;
	logic [STATE_W-1:0] prod_s2;
	logic [PROB_WIDTH-1:0] low_s2;
	logic [PROB_WIDTH-1:0] start_s2;
	logic [SYM_W-1:0]   sym_s2;
	logic               strobe_q;
	logic [SYM_W-1:0]   symbol_q;
	logic               consumed_q;
	logic               err_q;

	logic [CUM_W-1:0]   base_now;
	logic [SYM_W-1:0]   sym_now;
	logic [CUM_W:0]     cum_sum;
	logic [CUM_W:0]     fill_addr;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [PROB_WIDTH-1:0] ram_raddr;
	logic [FQ_W:0]      fq_ext;
	logic [PROD_W-1:0]  prod_full;
	logic [STATE_W-1:0] nx;
	logic               need_refill;
	logic               underflow;
	logic [STATE_W-1:0] nx_final;

	// load side: the first symbol restarts the running start and symbol index
	assign base_now = is_first_symbol ? '0 : cum_q;
	assign sym_now  = is_first_symbol ? '0 : sym_cnt_q;
	assign cum_sum  = {1'b0, base_now} + {1'b0, freq};

	assign fill_addr = {1'b0, fill_base_q} + (CUM_W + 1)'(fill_idx_q);
	assign ram_we    = ctrl.fill_en && (fill_addr < (CUM_W + 1)'(SLOTS));
	assign ram_wdata = {FQ_W'(fill_freq_q - FQ_W'(1)), fill_base_q[PROB_WIDTH-1:0], fill_sym_q};

	assign status.freq_zero = (freq == '0);
	assign status.fill_last = (fill_idx_q == FQ_W'(fill_freq_q - FQ_W'(1)));

	// decode side
	assign ram_raddr = lane_q[ptr_q][PROB_WIDTH-1:0];
	assign fq_ext    = {1'b0, ram_rdata[ENTRY_W-1 -: FQ_W]} + (FQ_W + 1)'(1);
	assign prod_full = PROD_W'(fq_ext) * PROD_W'(x_s1[STATE_W-1:PROB_WIDTH]);

	assign nx          = prod_s2 + STATE_W'(low_s2) - STATE_W'(start_s2);
	assign need_refill = (nx < STATE_W'(RENORM_LOW));
	assign underflow   = need_refill && !word_valid_q;
	assign nx_final    = need_refill ? {nx[STATE_W-WORD_W-1:0], word_q} : nx;

	rdel_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_addr[PROB_WIDTH-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cum_q     <= '0;
			sym_cnt_q <= '0;
			ptr_q     <= '0;
			strobe_q  <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				lane_q[i] <= '0;
			end
		end else begin
			strobe_q <= ctrl.dec_wb;
			if (ctrl.ld_accept) begin
				cum_q     <= (cum_sum > (CUM_W + 1)'(CUM_MAX)) ? CUM_W'(CUM_MAX)
				                                                : cum_sum[CUM_W-1:0];
				sym_cnt_q <= sym_now + SYM_W'(1);
			end
			if (ctrl.lane_accept) begin
				for (int i = 0; i < LANES; i++) begin
					if (32'(lane) == i) begin
						lane_q[i] <= init_state;
					end
				end
				ptr_q <= '0;
			end
			// an underflow leaves the lane state and pointer alone
			if (ctrl.dec_wb && !underflow) begin
				for (int i = 0; i < LANES; i++) begin
					if (ptr_q == PTR_W'(i)) begin
						lane_q[i] <= nx_final;
					end
				end
				ptr_q <= (ptr_q == PTR_W'(LANES - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_accept) begin
			fill_base_q <= base_now;
			fill_freq_q <= freq;
			fill_sym_q  <= sym_now;
			fill_idx_q  <= '0;
		end else if (ctrl.fill_en) begin
			fill_idx_q <= fill_idx_q + FQ_W'(1);
		end
		if (ctrl.dec_accept) begin
			word_q       <= refill_word;
			word_valid_q <= word_valid;
		end
		if (ctrl.dec_rd) begin
			x_s1 <= lane_q[ptr_q];
		end
		if (ctrl.dec_mul) begin
			prod_s2  <= prod_full[STATE_W-1:0];
			low_s2   <= x_s1[PROB_WIDTH-1:0];
			start_s2 <= ram_rdata[SYM_W +: PROB_WIDTH];
			sym_s2   <= ram_rdata[SYM_W-1:0];
		end
		if (ctrl.dec_wb) begin
			symbol_q   <= sym_s2;
			consumed_q <= need_refill && word_valid_q;
			err_q      <= underflow;
		end
	end

	assign result_strobe   = strobe_q;
	assign symbol          = symbol_q;
	assign word_consumed   = consumed_q;
	assign underflow_error = err_q;

endmodule

// ===== rtl/rans_decoder_eight_lanes_unit.sv =====
// top level of the eight-lane rans decoder: controller plus datapath
// depends on rdel_pkg, rdel_ctrl, rdel_datapath
//
// An item is taken at a clock edge where start is high and busy is low.
// A frequency load holds busy while its slots are filled, one slot written per cycle
// through the slot memory's single write port (slots past the table end are not
// written); a zero frequency does not raise busy, nor does a lane load. A decode
// item walks slot read, multiply and state update: its result shows on
// result_strobe for one cycle only, and the next item can be taken in that same
// cycle, not before. The receiver cannot stall the result; it must take it in the
// strobe cycle. Decoding must only follow a complete table load whose frequencies
// sum to the table size.
module rans_decoder_eight_lanes_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rdel_pkg::REQ_W-1:0]   req_type,
	input  logic [rdel_pkg::FQ_W-1:0]    freq,
	input  logic                         is_first_symbol,
	input  logic [rdel_pkg::LANE_W-1:0]  lane,
	input  logic [rdel_pkg::STATE_W-1:0] init_state,
	input  logic [rdel_pkg::WORD_W-1:0]  refill_word,
	input  logic                         word_valid,
	output logic                         result_strobe,
	output logic [rdel_pkg::SYM_W-1:0]   symbol,
	output logic                         word_consumed,
	output logic                         underflow_error
);
	import rdel_pkg::*;

	ctrl_t   ctrl;
	status_t status;

	rdel_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.status  (status),
		.ctrl    (ctrl),
		.busy    (busy)
	);

	rdel_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.status         (status),
		.freq           (freq),
		.is_first_symbol(is_first_symbol),
		.lane           (lane),
		.init_state     (init_state),
		.refill_word    (refill_word),
		.word_valid     (word_valid),
		.result_strobe  (result_strobe),
		.symbol         (symbol),
		.word_consumed  (word_consumed),
		.underflow_error(underflow_error)
	);

	// a result only follows a busy decode sequence
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result strobe without preceding decode");

	a_consume_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !(word_consumed && underflow_error))
		else $error("word consumed and underflow flagged together");

	a_decode_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_DEC) |-> ##4 result_strobe)
		else $error("decode item gave no result in time");

	a_decode_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_DEC) |=> busy)
		else $error("decode item accepted without going busy");

endmodule

// ===== dv/tb_rans_decoder_eight_lanes_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for rans_decoder_eight_lanes_unit: directed rows, then random
// table loads, lane loads and decode streams checked against an in-bench decoder model
// depends on rdel_pkg and the rtl of rans_decoder_eight_lanes_unit
module tb_rans_decoder_eight_lanes_unit;
	import rdel_pkg::*;

	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
	localparam int unsigned ITEMS_PER_PHASE = 617;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned MAX_PRINTS = 100;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [FQ_W-1:0]    freq;
		logic               is_first_symbol;
		logic [LANE_W-1:0]  lane;
		logic [STATE_W-1:0] init_state;
		logic [WORD_W-1:0]  refill_word;
		logic               word_valid;
	} req_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             word_consumed;
		logic             underflow_error;
	} sym_result_t;

	typedef struct packed {
		req_item_t   stim;
		bit          typed;
		sym_result_t want;
	} dir_row_t;

	typedef struct packed {
		logic [FQ_W-1:0]       fq_m1;
		logic [PROB_WIDTH-1:0] base;
		logic [SYM_W-1:0]      sym;
	} slot_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [REQ_W-1:0]     req_type;
	logic [FQ_W-1:0]      freq;
	logic                 is_first_symbol;
	logic [LANE_W-1:0]    lane;
	logic [STATE_W-1:0]   init_state;
	logic [WORD_W-1:0]    refill_word;
	logic                 word_valid;
	logic                 result_strobe;
	logic [SYM_W-1:0]     symbol;
	logic                 word_consumed;
	logic                 underflow_error;

	// decoder model state
	slot_t                slot_mem [SLOTS];
	logic [CUM_W-1:0]     cum_start;
	logic [SYM_W-1:0]     sym_index;
	logic [STATE_W-1:0]   lane_x [LANES];
	int unsigned          lane_ptr;

	sym_result_t          pending_symbols [$];
	dir_row_t             dir_rows [$];
	int unsigned          errors;
	int unsigned          cycles;
	int unsigned          items_done;
	int unsigned          idle_pct;

	rans_decoder_eight_lanes_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.freq            (freq),
		.is_first_symbol (is_first_symbol),
		.lane            (lane),
		.init_state      (init_state),
		.refill_word     (refill_word),
		.word_valid      (word_valid),
		.result_strobe   (result_strobe),
		.symbol          (symbol),
		.word_consumed   (word_consumed),
		.underflow_error (underflow_error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// updates the model for one accepted item, returns 1 when a symbol comes out
	function automatic bit apply_request(input req_item_t it, output sym_result_t r);
		int unsigned f, idx, j, k, fq;
		logic [STATE_W-1:0] x, nx;
		slot_t e;
		r = '0;
		case (it.req_type)
			REQ_LOAD: begin
				if (it.is_first_symbol) begin
					cum_start = '0;
					sym_index = '0;
				end
				f = 32'(it.freq);
				for (j = 0; j < f; j++) begin
					idx = cum_start + j;
					// slots past the end of the table are dropped
					if (idx < SLOTS)
						slot_mem[idx[PROB_WIDTH-1:0]] = '{fq_m1: FQ_W'(f - 1),
							base: cum_start[PROB_WIDTH-1:0], sym: sym_index};
				end
				if (cum_start + f > CUM_MAX)
					cum_start = CUM_W'(CUM_MAX);
				else
					cum_start = CUM_W'(cum_start + f);
				sym_index = sym_index + 1'b1;
				return 1'b0;
			end
			REQ_LANE: begin
				if (it.lane < LANES) begin
					lane_x[it.lane] = it.init_state;
					lane_ptr = 0;
				end
				return 1'b0;
			end
			REQ_DEC: begin
				k = lane_ptr % LANES;
				x = lane_x[k[PTR_W-1:0]];
				e = slot_mem[x[PROB_WIDTH-1:0]];
				fq = e.fq_m1 + 1;
				nx = STATE_W'(fq * (x >> PROB_WIDTH) + x[PROB_WIDTH-1:0] - e.base);
				if (nx < RENORM_LOW) begin
					if (it.word_valid) begin
						nx = {nx[STATE_W-WORD_W-1:0], it.refill_word};
						r.word_consumed = 1'b1;
					end else begin
						r.underflow_error = 1'b1;
					end
				end
				// underflow leaves state and pointer alone
				if (!r.underflow_error) begin
					lane_x[k[PTR_W-1:0]] = nx;
					lane_ptr = (k + 1) % LANES;
				end
				r.symbol = e.sym;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic issue(input req_item_t it, input bit typed, input sym_result_t want);
		sym_result_t got;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		req_type        <= it.req_type;
		freq            <= it.freq;
		is_first_symbol <= it.is_first_symbol;
		lane            <= it.lane;
		init_state      <= it.init_state;
		refill_word     <= it.refill_word;
		word_valid      <= it.word_valid;
		start           <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		if (apply_request(it, got))
			pending_symbols.push_back(typed ? want : got);
		if (it.req_type != REQ_NONE)
			items_done++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_symbols.size() != 0) @(posedge clk);
	endtask

	function automatic req_item_t noise_fields();
		req_item_t it;
		it.req_type        = REQ_W'($urandom());
		it.freq            = FQ_W'($urandom());
		it.is_first_symbol = 1'($urandom());
		it.lane            = LANE_W'($urandom());
		it.init_state      = $urandom();
		it.refill_word     = WORD_W'($urandom());
		it.word_valid      = 1'($urandom());
		return it;
	endfunction

	// one table load, one round of lane loads, then a run of decodes with some noise
	task automatic run_stream();
		int unsigned nsym, rem, left, f, flavor, ndec, r, i, off, pick;
		req_item_t it;
		nsym = ($urandom_range(7) == 0) ? $urandom_range(256, 300) : $urandom_range(1, 40);
		// 0 short of the table size, 1 overshoot, 2 no restart flag, else clean
		flavor = $urandom_range(11);
		rem = SLOTS;
		for (i = 0; i < nsym; i++) begin
			it = noise_fields();
			it.req_type = REQ_LOAD;
			it.is_first_symbol = (i == 0) && (flavor != 2);
			left = nsym - i;
			if (left == 1)
				f = (flavor == 0) ? rem / 2 : (flavor == 1) ? rem + $urandom_range(1, 100) : rem;
			else if ($urandom_range(7) == 0)
				f = 0;
			else
				f = $urandom_range(0, 2 * rem / left);
			if (left > 1)
				rem -= f;
			it.freq = FQ_W'(f);
			issue(it, 1'b0, '0);
		end
		off = $urandom_range(LANES - 1);
		for (i = 0; i < LANES; i++) begin
			it = noise_fields();
			it.req_type = REQ_LANE;
			it.lane = LANE_W'((i + off) % LANES);
			pick = $urandom_range(9);
			if (pick == 1)
				it.init_state = $urandom_range(0, 65535);
			else if (pick != 0)
				it.init_state = $urandom_range(32'h0001_0000, 32'hffff_ffff);
			issue(it, 1'b0, '0);
		end
		ndec = $urandom_range(30, 120);
		// the decode run stops early once the phase has its items
		for (i = 0; i < ndec && items_done < ITEMS_PER_PHASE; i++) begin
			it = noise_fields();
			r = $urandom_range(99);
			if (r < 3) begin
				it.req_type = REQ_NONE;
			end else if (r < 6) begin
				it.req_type = REQ_LANE;
			end else if (r < 7) begin
				it.req_type = REQ_LOAD;
				it.freq = FQ_W'($urandom_range(0, 8));
			end else begin
				it.req_type = REQ_DEC;
				it.word_valid = ($urandom_range(15) != 0);
			end
			issue(it, 1'b0, '0);
		end
	endtask

	function automatic dir_row_t row(input logic [REQ_W-1:0] rq, input int unsigned fq,
		input logic fs, input logic [LANE_W-1:0] ln, input logic [STATE_W-1:0] st,
		input logic [WORD_W-1:0] wd, input logic wv, input bit ty, input sym_result_t w);
		dir_row_t d;
		d.stim = '{req_type: rq, freq: FQ_W'(fq), is_first_symbol: fs, lane: ln,
			init_state: st, refill_word: wd, word_valid: wv};
		d.typed = ty;
		d.want = w;
		return d;
	endfunction

	always @(posedge clk) begin : result_check
		sym_result_t want;
		if (result_strobe === 1'b1) begin
			if (pending_symbols.size() == 0) begin
				flag("result with nothing pending, symbol", 32'(symbol), 0);
			end else begin
				want = pending_symbols.pop_front();
				if (symbol !== want.symbol)
					flag("symbol", 32'(symbol), 32'(want.symbol));
				if (word_consumed !== want.word_consumed)
					flag("word_consumed", 32'(word_consumed), 32'(want.word_consumed));
				if (underflow_error !== want.underflow_error)
					flag("underflow_error", 32'(underflow_error), 32'(want.underflow_error));
			end
		end else if (arst_n === 1'b1 && result_strobe !== 1'b0) begin
			flag("result_strobe unknown", 32'(result_strobe), 0);
		end
	end

	initial begin
		int unsigned ph, i;
		items_done = 0;
		idle_pct = 34;
		cum_start = '0;
		sym_index = '0;
		lane_ptr = 0;
		foreach (lane_x[n]) lane_x[n] = '0;

		arst_n          <= 1'b0;
		start           <= 1'b0;
		req_type        <= REQ_LOAD;
		freq            <= '0;
		is_first_symbol <= 1'b0;
		lane            <= '0;
		init_state      <= '0;
		refill_word     <= '0;
		word_valid      <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole table to symbol 0 first, so no decode ever reads an unwritten slot
		dir_rows.push_back(row(REQ_LOAD, 4096, 1, 0, 0, 0, 0, 0, '0));
		// zero state, no word: underflow
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h0, 0, 1, {8'd0, 1'b0, 1'b1}));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'hffff, 1, 1, {8'd0, 1'b1, 1'b0}));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h1234, 1, 1, {8'd0, 1'b1, 1'b0}));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 7, 32'h0001_0000, 0, 0, 0, '0));
		// no refill needed, word offered but not taken
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'haaaa, 1, 0, '0));
		dir_rows.push_back(row(REQ_NONE, 8191, 1, 7, 32'hffff_ffff, 16'hffff, 1, 0, '0));
		// zero-frequency symbol, then overflow past the table end with saturation
		dir_rows.push_back(row(REQ_LOAD, 0, 1, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LOAD, 1, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LOAD, 4094, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LOAD, 8191, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LOAD, 3, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 0, 32'h0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 1, 32'h0000_0fff, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 2, 32'h8000_0005, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h0000, 1, 1, {8'd1, 1'b1, 1'b0}));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h0000, 0, 1, {8'd3, 1'b0, 1'b1}));
		// same lane again since the underflow held the pointer
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h5a5a, 1, 1, {8'd3, 1'b1, 1'b0}));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h0f0f, 1, 0, '0));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h0000, 0, 1, {8'd1, 1'b0, 1'b1}));
		// frequency above the table size is kept as given
		dir_rows.push_back(row(REQ_LOAD, 4097, 1, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'hffff, 1, 0, '0));
		dir_rows.push_back(row(REQ_LANE, 0, 0, 3, 32'h7654_3210, 0, 0, 0, '0));
		dir_rows.push_back(row(REQ_DEC, 0, 0, 0, 0, 16'h8001, 1, 0, '0));

		for (i = 0; i < dir_rows.size(); i++)
			issue(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		for (ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 34 : (ph == 1) ? 72 : 0;
			items_done = 0;
			while (items_done < ITEMS_PER_PHASE) run_stream();
			// sender holds off until every pending symbol is out
			drain();
		end
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
